### design/uvs_pkg.sv
package uvs_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_RADIUS   = 3'd0;
   localparam logic [2:0] CSR_SECTORS  = 3'd1;
   localparam logic [2:0] CSR_STACKS   = 3'd2;
   localparam logic [2:0] CSR_CENTER_X = 3'd3;
   localparam logic [2:0] CSR_CENTER_Y = 3'd4;
   localparam logic [2:0] CSR_CENTER_Z = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_VERTEX   = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_RANGE    = 2'd2;

   // Input opcodes.
   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_CELL   = 1'b1;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_DIVISIONS = 256;
   localparam int DEF_CORDIC_STAGES = 16;

   // Quotient bits of the phase dividers and the CORDIC start value.
   localparam int DIV_BITS = 33;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;

   // Item information that travels along the whole pipeline.
   typedef struct packed {
      logic       op;
      logic [8:0] stack_i;
      logic [8:0] sector_j;
      logic       neg_s;
      logic       neg_t;
   } meta_type;

   // Partial remainders and quotients of the two phase divisions.
   typedef struct packed {
      logic [8:0]  rem_t;
      logic [32:0] quo_t;
      logic [8:0]  rem_s;
      logic [32:0] quo_s;
   } div_type;

   // Rotation state of the two CORDIC lanes.
   typedef struct packed {
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [33:0] zs;
      logic signed [33:0] xt;
      logic signed [33:0] yt;
      logic signed [33:0] zt;
   } rot_type;

   // Arctangent of 2^-k as a fraction of a full turn, 2^32 per turn.
   function automatic logic [31:0] uvs_atan(input int k);
      logic [31:0] a;
      case (k)
         0: a = 32'd536870912;   1: a = 32'd316933406;   2: a = 32'd167458907;
         3: a = 32'd85004756;    4: a = 32'd42667331;    5: a = 32'd21354465;
         6: a = 32'd10679839;    7: a = 32'd5340245;     8: a = 32'd2670163;
         9: a = 32'd1335087;     10: a = 32'd667544;     11: a = 32'd333772;
         12: a = 32'd166886;     13: a = 32'd83443;      14: a = 32'd41722;
         15: a = 32'd20861;      16: a = 32'd10430;      17: a = 32'd5215;
         18: a = 32'd2608;       19: a = 32'd1304;       20: a = 32'd652;
         21: a = 32'd326;        22: a = 32'd163;        23: a = 32'd81;
         24: a = 32'd41;         25: a = 32'd20;         26: a = 32'd10;
         27: a = 32'd5;          28: a = 32'd3;          29: a = 32'd1;
         30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

### design/uvs_div_cell.sv
module uvs_div_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [8:0]         sectors,
   input  logic [8:0]         stacks,
   input  logic               in_valid,
   input  uvs_pkg::meta_type  in_meta,
   input  uvs_pkg::div_type   in_div,
   output logic               out_valid,
   output uvs_pkg::meta_type  out_meta,
   output uvs_pkg::div_type   out_div
);
   import uvs_pkg::*;

   logic       bit_t;
   logic       bit_s;
   logic [9:0] trial_t;
   logic [9:0] trial_s;
   logic       take_t;
   logic       take_s;
   logic [9:0] diff_t;
   logic [9:0] diff_s;

   logic     valid_ff;
   meta_type meta_ff;
   div_type  div_ff;
   div_type  div_in;

   // Numerator bit brought down in this cell: the index sits above the
   // binary point, half the divisor below it for rounding.
   generate
      if (BIT == 32) begin : g_top
         assign bit_t = in_meta.sector_j[0];
         assign bit_s = in_meta.stack_i[1];
      end else if (BIT == 31) begin : g_next
         assign bit_t = 1'b0;
         assign bit_s = in_meta.stack_i[0];
      end else if (BIT < 8) begin : g_low
         assign bit_t = sectors[BIT + 1];
         assign bit_s = stacks[BIT + 1];
      end else begin : g_zero
         assign bit_t = 1'b0;
         assign bit_s = 1'b0;
      end
   endgenerate

   // One restoring division step per lane.
   always_comb begin
      trial_t = {in_div.rem_t, bit_t};
      trial_s = {in_div.rem_s, bit_s};
      take_t  = (trial_t >= {1'b0, sectors});
      take_s  = (trial_s >= {1'b0, stacks});
      diff_t  = take_t ? (trial_t - {1'b0, sectors}) : trial_t;
      diff_s  = take_s ? (trial_s - {1'b0, stacks}) : trial_s;
      div_in.rem_t = diff_t[8:0];
      div_in.quo_t = {in_div.quo_t[31:0], take_t};
      div_in.rem_s = diff_s[8:0];
      div_in.quo_s = {in_div.quo_s[31:0], take_s};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff <= in_meta;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_div   = div_ff;

endmodule

### design/uvs_cordic_cell.sv
module uvs_cordic_cell #(
   parameter int K = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  uvs_pkg::meta_type  in_meta,
   input  uvs_pkg::rot_type   in_rot,
   output logic               out_valid,
   output uvs_pkg::meta_type  out_meta,
   output uvs_pkg::rot_type   out_rot
);
   import uvs_pkg::*;

   logic signed [33:0] angle;
   logic signed [33:0] dxs;
   logic signed [33:0] dys;
   logic signed [33:0] dxt;
   logic signed [33:0] dyt;

   logic     valid_ff;
   meta_type meta_ff;
   rot_type  rot_ff;
   rot_type  rot_in;

   assign angle = $signed({2'b00, uvs_atan(K)});

   // One micro-rotation on each lane, direction from the residual angle.
   always_comb begin
      dxs = in_rot.ys >>> K;
      dys = in_rot.xs >>> K;
      dxt = in_rot.yt >>> K;
      dyt = in_rot.xt >>> K;
      if (!in_rot.zs[33]) begin
         rot_in.xs = in_rot.xs - dxs;
         rot_in.ys = in_rot.ys + dys;
         rot_in.zs = in_rot.zs - angle;
      end else begin
         rot_in.xs = in_rot.xs + dxs;
         rot_in.ys = in_rot.ys - dys;
         rot_in.zs = in_rot.zs + angle;
      end
      if (!in_rot.zt[33]) begin
         rot_in.xt = in_rot.xt - dxt;
         rot_in.yt = in_rot.yt + dyt;
         rot_in.zt = in_rot.zt - angle;
      end else begin
         rot_in.xt = in_rot.xt + dxt;
         rot_in.yt = in_rot.yt - dyt;
         rot_in.zt = in_rot.zt + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff <= in_meta;
         rot_ff  <= rot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_rot   = rot_ff;

endmodule

### design/uvs_vertex_math.sv
module uvs_vertex_math (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [30:0]        radius,
   input  logic signed [31:0] center_x,
   input  logic signed [31:0] center_y,
   input  logic signed [31:0] center_z,
   input  logic               in_valid,
   input  uvs_pkg::meta_type  in_meta,
   input  uvs_pkg::rot_type   in_rot,
   output logic               out_valid,
   output uvs_pkg::meta_type  out_meta,
   output logic signed [31:0] pos_x,
   output logic signed [31:0] pos_y,
   output logic signed [31:0] pos_z,
   output logic signed [15:0] norm_x,
   output logic signed [15:0] norm_y,
   output logic signed [15:0] norm_z
);
   import uvs_pkg::*;

   // Rounds a Q1.30 value to Q2.14 and clamps it to plus or minus one.
   function automatic logic signed [15:0] to_norm(input logic signed [33:0] n);
      logic signed [33:0] r;
      logic signed [17:0] q;
      logic signed [15:0] o;
      r = n + 34'sd32768;
      q = r[33:16];
      if (q > 18'sd16384) begin
         o = 16'sd16384;
      end else if (q < -18'sd16384) begin
         o = -16'sd16384;
      end else begin
         o = q[15:0];
      end
      return o;
   endfunction

   // Adds the center to a rounded scaled product and saturates to 32 bits.
   function automatic logic signed [31:0] to_pos(input logic signed [31:0] c,
                                                 input logic signed [65:0] p);
      logic signed [65:0] r;
      logic signed [36:0] s;
      logic signed [31:0] o;
      r = p + 66'sd536870912;
      s = {{5{c[31]}}, c} + {r[65], r[65:30]};
      if (s > 37'sd2147483647) begin
         o = 32'sh7FFFFFFF;
      end else if (s < -37'sd2147483648) begin
         o = 32'sh80000000;
      end else begin
         o = s[31:0];
      end
      return o;
   endfunction

   logic [4:0] valid_ff;
   meta_type   meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff;

   logic signed [33:0] cs1_ff, ss1_ff, ct1_ff, st1_ff;
   logic signed [67:0] pxc2_ff, pyc2_ff;
   logic signed [33:0] nz2_ff;
   logic signed [33:0] nx3_ff, ny3_ff, nz3_ff;
   logic signed [65:0] rx4_ff, ry4_ff, rz4_ff;
   logic signed [15:0] nnx4_ff, nny4_ff, nnz4_ff;
   logic signed [31:0] px5_ff, py5_ff, pz5_ff;
   logic signed [15:0] nnx5_ff, nny5_ff, nnz5_ff;

   logic signed [67:0] rnd_x;
   logic signed [67:0] rnd_y;
   logic signed [31:0] radius_s;

   assign rnd_x    = pxc2_ff + 68'sd536870912;
   assign rnd_y    = pyc2_ff + 68'sd536870912;
   assign radius_s = $signed({1'b0, radius});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // Undo the quadrant fold, form the normal, scale, offset and saturate.
   always_ff @(posedge clock) begin
      if (adv) begin
         meta1_ff <= in_meta;
         cs1_ff   <= in_meta.neg_s ? -in_rot.xs : in_rot.xs;
         ss1_ff   <= in_meta.neg_s ? -in_rot.ys : in_rot.ys;
         ct1_ff   <= in_meta.neg_t ? -in_rot.xt : in_rot.xt;
         st1_ff   <= in_meta.neg_t ? -in_rot.yt : in_rot.yt;

         meta2_ff <= meta1_ff;
         pxc2_ff  <= cs1_ff * ct1_ff;
         pyc2_ff  <= cs1_ff * st1_ff;
         nz2_ff   <= ss1_ff;

         meta3_ff <= meta2_ff;
         nx3_ff   <= rnd_x[63:30];
         ny3_ff   <= rnd_y[63:30];
         nz3_ff   <= nz2_ff;

         meta4_ff <= meta3_ff;
         rx4_ff   <= nx3_ff * radius_s;
         ry4_ff   <= ny3_ff * radius_s;
         rz4_ff   <= nz3_ff * radius_s;
         nnx4_ff  <= to_norm(nx3_ff);
         nny4_ff  <= to_norm(ny3_ff);
         nnz4_ff  <= to_norm(nz3_ff);

         meta5_ff <= meta4_ff;
         px5_ff   <= to_pos(center_x, rx4_ff);
         py5_ff   <= to_pos(center_y, ry4_ff);
         pz5_ff   <= to_pos(center_z, rz4_ff);
         nnx5_ff  <= nnx4_ff;
         nny5_ff  <= nny4_ff;
         nnz5_ff  <= nnz4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_meta  = meta5_ff;
   assign pos_x     = px5_ff;
   assign pos_y     = py5_ff;
   assign pos_z     = pz5_ff;
   assign norm_x    = nnx5_ff;
   assign norm_y    = nny5_ff;
   assign norm_z    = nnz5_ff;

endmodule

### design/uv_sphere_mesh_generator.sv
// Channel   Direction  Handshake                  Beat contents
// req_      in         req_valid / req_ready      opcode, stack index, sector index
// rsp_      out        rsp_valid / rsp_ready      kind, position, normal, corners, last
// csr_      in         csr_write_enable           register index, write data
//
// One item enters per cycle while the chain is not stalled; every item runs through
// 33 divider cells, CORDIC_STAGES rotation cells and five math stages before the
// output register. A cell item that yields two triangles holds the output register
// for two beats. Reset is synchronous and clears the valid bits and the configuration
// registers to their defaults. When the output register holds a beat that is not
// taken, the whole chain stalls.
module uv_sphere_mesh_generator #(
   parameter int MAX_DIVISIONS = uvs_pkg::DEF_MAX_DIVISIONS,
   parameter int CORDIC_STAGES = uvs_pkg::DEF_CORDIC_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [8:0]         req_stack_index,
   input  logic [8:0]         req_sector_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_corner_a,
   output logic [16:0]        rsp_corner_b,
   output logic [16:0]        rsp_corner_c,
   output logic               rsp_last_of_run,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import uvs_pkg::*;

   // Configuration registers.
   logic [30:0]        radius_ff;
   logic [8:0]         sectors_ff;
   logic [8:0]         stacks_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [8:0]         csr_v9;

   assign csr_v9 = csr_data[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 31'd65536;
         sectors_ff <= 9'd36;
         stacks_ff  <= 9'd18;
         cx_ff      <= '0;
         cy_ff      <= '0;
         cz_ff      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIUS: begin
               radius_ff <= csr_data[30:0];
            end
            CSR_SECTORS: begin
               if (csr_v9 >= 9'd3 && int'(csr_v9) <= MAX_DIVISIONS) begin
                  sectors_ff <= csr_v9;
               end
            end
            CSR_STACKS: begin
               if (csr_v9 >= 9'd2 && int'(csr_v9) <= MAX_DIVISIONS) begin
                  stacks_ff <= csr_v9;
               end
            end
            CSR_CENTER_X: begin
               cx_ff <= csr_data;
            end
            CSR_CENTER_Y: begin
               cy_ff <= csr_data;
            end
            CSR_CENTER_Z: begin
               cz_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The chain moves whenever the output register is empty or its beat is taken with no second triangle held.
   logic adv;
   logic rsp_valid_ff;
   logic pend_ff;

   assign adv       = !rsp_valid_ff || (rsp_ready && !pend_ff);
   assign req_ready = adv;

   // Divider cells: one quotient bit of both phases per cell.
   logic     div_v [0:DIV_BITS];
   meta_type div_m [0:DIV_BITS];
   div_type  div_d [0:DIV_BITS];

   always_comb begin
      div_v[0]          = req_valid;
      div_m[0].op       = req_opcode;
      div_m[0].stack_i  = req_stack_index;
      div_m[0].sector_j = req_sector_index;
      div_m[0].neg_s    = 1'b0;
      div_m[0].neg_t    = 1'b0;
      div_d[0].rem_t    = {1'b0, req_sector_index[8:1]};
      div_d[0].quo_t    = '0;
      div_d[0].rem_s    = {2'b00, req_stack_index[8:2]};
      div_d[0].quo_s    = '0;
   end

   genvar gk;
   generate
      for (gk = 0; gk < DIV_BITS; gk++) begin : g_div
         uvs_div_cell #(.BIT(DIV_BITS - 1 - gk)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .sectors   (sectors_ff),
            .stacks    (stacks_ff),
            .in_valid  (div_v[gk]),
            .in_meta   (div_m[gk]),
            .in_div    (div_d[gk]),
            .out_valid (div_v[gk + 1]),
            .out_meta  (div_m[gk + 1]),
            .out_div   (div_d[gk + 1])
         );
      end
   endgenerate

   // Phases as fractions of a turn, folded into the right half plane.
   logic [31:0] phase_s;
   logic [31:0] phase_t;
   logic        rot_v [0:CORDIC_STAGES];
   meta_type    rot_m [0:CORDIC_STAGES];
   rot_type     rot_d [0:CORDIC_STAGES];

   assign phase_t = div_d[DIV_BITS].quo_t[31:0];
   assign phase_s = 32'h40000000 - div_d[DIV_BITS].quo_s[31:0];

   always_comb begin
      rot_v[0]       = div_v[DIV_BITS];
      rot_m[0]       = div_m[DIV_BITS];
      rot_d[0].xs    = CORDIC_GAIN_Q30;
      rot_d[0].ys    = '0;
      rot_d[0].xt    = CORDIC_GAIN_Q30;
      rot_d[0].yt    = '0;
      rot_m[0].neg_s = (phase_s[31] != phase_s[30]);
      rot_m[0].neg_t = (phase_t[31] != phase_t[30]);
      if (phase_s[31] != phase_s[30]) begin
         rot_d[0].zs = $signed({2'b00, phase_s}) - 34'sh080000000;
      end else begin
         rot_d[0].zs = $signed({{2{phase_s[31]}}, phase_s});
      end
      if (phase_t[31] != phase_t[30]) begin
         rot_d[0].zt = $signed({2'b00, phase_t}) - 34'sh080000000;
      end else begin
         rot_d[0].zt = $signed({{2{phase_t[31]}}, phase_t});
      end
   end

   // Rotation cells.
   generate
      for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_rot
         uvs_cordic_cell #(.K(gk)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .in_valid  (rot_v[gk]),
            .in_meta   (rot_m[gk]),
            .in_rot    (rot_d[gk]),
            .out_valid (rot_v[gk + 1]),
            .out_meta  (rot_m[gk + 1]),
            .out_rot   (rot_d[gk + 1])
         );
      end
   endgenerate

   // Normal and position arithmetic.
   logic               m_valid;
   meta_type           m_meta;
   logic signed [31:0] m_px, m_py, m_pz;
   logic signed [15:0] m_nx, m_ny, m_nz;

   uvs_vertex_math u_math (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .radius    (radius_ff),
      .center_x  (cx_ff),
      .center_y  (cy_ff),
      .center_z  (cz_ff),
      .in_valid  (rot_v[CORDIC_STAGES]),
      .in_meta   (rot_m[CORDIC_STAGES]),
      .in_rot    (rot_d[CORDIC_STAGES]),
      .out_valid (m_valid),
      .out_meta  (m_meta),
      .pos_x     (m_px),
      .pos_y     (m_py),
      .pos_z     (m_pz),
      .norm_x    (m_nx),
      .norm_y    (m_ny),
      .norm_z    (m_nz)
   );

   // Range checks and grid indices of the item leaving the chain.
   logic [18:0] row_base;
   logic [16:0] k1, k2;
   logic        bad;
   logic        up, low;

   always_comb begin
      row_base = m_meta.stack_i * ({1'b0, sectors_ff} + 10'd1);
      k1       = row_base[16:0] + {8'd0, m_meta.sector_j};
      k2       = k1 + {8'd0, sectors_ff} + 17'd1;
      up       = (m_meta.stack_i != 9'd0);
      low      = (m_meta.stack_i != (stacks_ff - 9'd1));
      if (m_meta.op == OP_VERTEX) begin
         bad = (m_meta.stack_i > stacks_ff) || (m_meta.sector_j > sectors_ff);
      end else begin
         bad = (m_meta.stack_i >= stacks_ff) || (m_meta.sector_j >= sectors_ff);
      end
   end

   // Output register, with a second triangle kept aside for a full cell.
   logic [1:0]         kind_ff, kind_in;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [31:0] px_in, py_in, pz_in;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [15:0] nx_in, ny_in, nz_in;
   logic [16:0]        ca_ff, cb_ff, cc_ff;
   logic [16:0]        ca_in, cb_in, cc_in;
   logic               last_ff, last_in;
   logic [16:0]        pa_ff, pb_ff, pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_valid;
         pend_ff      <= m_valid && !bad && (m_meta.op == OP_CELL) && up && low;
      end else if (rsp_ready) begin
         pend_ff <= 1'b0;
      end
   end

   // Next beat: a new item when the chain moves, the held triangle when it is due.
   always_comb begin
      kind_in = kind_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      pz_in   = pz_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      nz_in   = nz_ff;
      ca_in   = ca_ff;
      cb_in   = cb_ff;
      cc_in   = cc_ff;
      last_in = last_ff;
      if (adv) begin
         px_in   = '0;
         py_in   = '0;
         pz_in   = '0;
         nx_in   = '0;
         ny_in   = '0;
         nz_in   = '0;
         ca_in   = '0;
         cb_in   = '0;
         cc_in   = '0;
         last_in = 1'b1;
         if (bad) begin
            kind_in = KIND_RANGE;
         end else if (m_meta.op == OP_VERTEX) begin
            kind_in = KIND_VERTEX;
            px_in   = m_px;
            py_in   = m_py;
            pz_in   = m_pz;
            nx_in   = m_nx;
            ny_in   = m_ny;
            nz_in   = m_nz;
         end else if (up) begin
            kind_in = KIND_TRIANGLE;
            ca_in   = k1;
            cb_in   = k2;
            cc_in   = k1 + 17'd1;
            last_in = !low;
         end else begin
            kind_in = KIND_TRIANGLE;
            ca_in   = k1 + 17'd1;
            cb_in   = k2;
            cc_in   = k2 + 17'd1;
         end
      end else if (rsp_ready && pend_ff) begin
         ca_in   = pa_ff;
         cb_in   = pb_ff;
         cc_in   = pc_ff;
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nz_ff   <= nz_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      cc_ff   <= cc_in;
      last_ff <= last_in;
      if (adv) begin
         pa_ff <= k1 + 17'd1;
         pb_ff <= k2;
         pc_ff <= k2 + 17'd1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_norm_x      = nx_ff;
   assign rsp_norm_y      = ny_ff;
   assign rsp_norm_z      = nz_ff;
   assign rsp_corner_a    = ca_ff;
   assign rsp_corner_b    = cb_ff;
   assign rsp_corner_c    = cc_ff;
   assign rsp_last_of_run = last_ff;

   // A held second triangle always sits behind a first triangle on the port.
   a_pend_behind_tri : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (rsp_valid_ff && kind_ff == KIND_TRIANGLE && !last_ff))
      else $error("second triangle pending without a first one in the output");

   // The chain never moves while an untaken beat sits in the output register.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("chain advanced under a stalled output beat");

   // Division counts stay at or above their lower bounds whatever is written.
   a_counts_legal : assert property (@(posedge clock) disable iff (reset)
      (sectors_ff >= 9'd3) && (stacks_ff >= 9'd2))
      else $error("division count register out of range");

endmodule

### bench/uvs_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register ports of the sphere generator.
// It predicts every response beat and compares it with what the block sends.
module uvs_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_opcode,
   input  logic [8:0]         req_stack_index,
   input  logic [8:0]         req_sector_index,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_result_kind,
   input  logic signed [31:0] rsp_pos_x,
   input  logic signed [31:0] rsp_pos_y,
   input  logic signed [31:0] rsp_pos_z,
   input  logic signed [15:0] rsp_norm_x,
   input  logic signed [15:0] rsp_norm_y,
   input  logic signed [15:0] rsp_norm_z,
   input  logic [16:0]        rsp_corner_a,
   input  logic [16:0]        rsp_corner_b,
   input  logic [16:0]        rsp_corner_c,
   input  logic               rsp_last_of_run,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 vertex_seen,
   output int                 triangle_seen,
   output int                 range_seen
);
   import uvs_pkg::*;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [16:0]        ca;
      logic [16:0]        cb;
      logic [16:0]        cc;
      logic               last;
   } mesh_beat_type;

   // Arctangent of 2^-k in units of 2^32 per turn.
   localparam logic [31:0] ATAN_TURN [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679839,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861};

   // Local copy of the registers.
   logic [30:0] radius;
   logic [8:0]  sectors;
   logic [8:0]  stacks;
   longint      cen_x, cen_y, cen_z;

   mesh_beat_type expected_beats[$];

   // Appends one predicted beat at the tail of the queue.
   function automatic void add_expected(input mesh_beat_type b);
      expected_beats = {expected_beats, b};
   endfunction

   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   // Sine and cosine in Q1.30 of a phase given as a fraction of a turn.
   function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                   output longint s);
      longint x, y, z, dx, dy;
      bit     flip;
      x = 652032875;
      y = 0;
      flip = 0;
      if (phase >= 32'h4000_0000 && phase < 32'hC000_0000) begin
         z = longint'(phase) - 64'sh8000_0000;
         flip = 1;
      end else if (phase >= 32'hC000_0000) begin
         z = longint'(phase) - 64'sh1_0000_0000;
      end else begin
         z = longint'(phase);
      end
      for (int k = 0; k < 16; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[k]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [31:0] place(longint cen, longint n30);
      longint p;
      p = cen + round_shift(longint'(radius) * n30, 30);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic logic [15:0] unit_q14(longint n30);
      longint n;
      n = round_shift(n30, 16);
      if (n > 16384) n = 16384;
      if (n < -16384) n = -16384;
      return n[15:0];
   endfunction

   // Expected beats of one request.
   task automatic predict_mesh(input logic op, input logic [8:0] i,
                               input logic [8:0] j);
      mesh_beat_type b;
      logic [31:0] ps, pt;
      longint cs, ss, ct, st, n_x, n_y;
      logic [16:0] k1, k2;
      b = '0;
      b.last = 1;
      if (op == OP_VERTEX) begin
         if (i > stacks || j > sectors) begin
            b.kind = KIND_RANGE;
            add_expected(b);
            return;
         end
         pt = 32'(((longint'(j) << 32) + sectors / 2) / sectors);
         ps = 32'h4000_0000 - 32'(((longint'(i) << 31) + stacks / 2) / stacks);
         sin_cos(ps, cs, ss);
         sin_cos(pt, ct, st);
         n_x = round_shift(cs * ct, 30);
         n_y = round_shift(cs * st, 30);
         b.kind = KIND_VERTEX;
         b.px = place(cen_x, n_x);
         b.py = place(cen_y, n_y);
         b.pz = place(cen_z, ss);
         b.nx = unit_q14(n_x);
         b.ny = unit_q14(n_y);
         b.nz = unit_q14(ss);
         add_expected(b);
      end else begin
         if (i >= stacks || j >= sectors) begin
            b.kind = KIND_RANGE;
            add_expected(b);
            return;
         end
         k1 = 17'(i) * (17'(sectors) + 17'd1) + 17'(j);
         k2 = k1 + 17'(sectors) + 17'd1;
         b.kind = KIND_TRIANGLE;
         // The top row has no upper triangle, the bottom row no lower one.
         if (i != 0) begin
            b.ca = k1; b.cb = k2; b.cc = k1 + 17'd1;
            b.last = (i == stacks - 1);
            add_expected(b);
         end
         if (i != stacks - 1) begin
            b.ca = k1 + 17'd1; b.cb = k2; b.cc = k2 + 17'd1;
            b.last = 1;
            add_expected(b);
         end
      end
   endtask

   assign pending = expected_beats.size();

   always @(posedge clock) begin
      mesh_beat_type got, want;
      if (reset) begin
         radius <= 31'd65536;
         sectors <= 9'd36;
         stacks <= 9'd18;
         cen_x <= 0; cen_y <= 0; cen_z <= 0;
         fail_count <= 0;
         vertex_seen <= 0; triangle_seen <= 0; range_seen <= 0;
         expected_beats.delete();
      end else begin
         // Register writes must land only while the block is idle; the checker does not enforce it.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RADIUS: radius <= csr_data[30:0];
               CSR_SECTORS:
                  if (csr_data[8:0] >= 3 && csr_data[8:0] <= 256) sectors <= csr_data[8:0];
               CSR_STACKS:
                  if (csr_data[8:0] >= 2 && csr_data[8:0] <= 256) stacks <= csr_data[8:0];
               CSR_CENTER_X: cen_x <= longint'(signed'(csr_data));
               CSR_CENTER_Y: cen_y <= longint'(signed'(csr_data));
               CSR_CENTER_Z: cen_z <= longint'(signed'(csr_data));
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_mesh(req_opcode, req_stack_index, req_sector_index);
         // Compare each response beat with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_kind, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x,
                    rsp_norm_y, rsp_norm_z, rsp_corner_a, rsp_corner_b, rsp_corner_c,
                    rsp_last_of_run};
            case (got.kind)
               KIND_VERTEX:   vertex_seen <= vertex_seen + 1;
               KIND_TRIANGLE: triangle_seen <= triangle_seen + 1;
               default:       range_seen <= range_seen + 1;
            endcase
            if (expected_beats.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected beat %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import uvs_pkg::*;

   localparam int DRAIN_CYCLES = 70;
   localparam int IDLE_LIMIT   = 20000;

   logic               clock, reset;
   logic               req_valid, req_ready, req_opcode;
   logic [8:0]         req_stack_index, req_sector_index;
   logic               rsp_valid, rsp_ready;
   logic [1:0]         rsp_result_kind;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0]        rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic               rsp_last_of_run;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   int  fail_count, pending, vertex_seen, triangle_seen, range_seen;
   int  items_sent;
   bit  steady;   // when set, neither side idles
   int  sectors_now, stacks_now;

   uv_sphere_mesh_generator dut (.*);

   uvs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Watchdog: ends the run when nothing moves for too long.
   int quiet;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet <= 0;
      else if (quiet >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d beats outstanding", pending);
         $display("tb_top: FAIL");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   // Response side: random stalls before each beat.
   initial begin
      int w;
      rsp_ready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = steady ? 0 : $urandom_range(0, 9);
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_item(input logic op, input logic [8:0] i, input logic [8:0] j);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_stack_index <= i;
      req_sector_index <= j;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // One register write, after which the enable is driven low again.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   // Pause until every predicted beat has arrived and the pipeline is empty.
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mesh(input logic [31:0] r, input int sec, input int stk,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_SECTORS, sec);
      write_reg(CSR_STACKS, stk);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_CENTER_Z, cz);
      if (sec >= 3 && sec <= 256) sectors_now = sec;
      if (stk >= 2 && stk <= 256) stacks_now = stk;
   endtask

   // Mostly in-range requests, with some that sit past the edges or are arbitrary.
   task automatic random_items(input int count);
      int pick;
      logic op;
      logic [8:0] i, j;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         op = 1'($urandom_range(0, 1));
         if (pick < 80) begin
            i = 9'($urandom_range(0, stacks_now - (op == OP_CELL)));
            j = 9'($urandom_range(0, sectors_now - (op == OP_CELL)));
         end else if (pick < 90) begin
            i = $urandom_range(0, 1) ? 9'(stacks_now + $urandom_range(0, 1)) : 9'd0;
            j = $urandom_range(0, 1) ? 9'(sectors_now + $urandom_range(0, 1)) : 9'd0;
         end else begin
            i = 9'($urandom);
            j = 9'($urandom);
         end
         send_item(op, i, j);
      end
   endtask

   task automatic directed_items();
      send_item(OP_VERTEX, 9'd0, 9'd0);
      send_item(OP_VERTEX, 9'(stacks_now), 9'(sectors_now));
      send_item(OP_VERTEX, 9'(stacks_now / 2), 9'(sectors_now / 4));
      send_item(OP_VERTEX, 9'(stacks_now + 1), 9'd0);
      send_item(OP_VERTEX, 9'd0, 9'(sectors_now + 1));
      send_item(OP_VERTEX, 9'h1FF, 9'h1FF);
      send_item(OP_CELL, 9'd0, 9'd0);
      send_item(OP_CELL, 9'(stacks_now - 1), 9'(sectors_now - 1));
      send_item(OP_CELL, 9'(stacks_now / 2), 9'd1);
      send_item(OP_CELL, 9'(stacks_now), 9'd0);
      send_item(OP_CELL, 9'd0, 9'(sectors_now));
      send_item(OP_CELL, 9'h1FF, 9'h1FF);
   endtask

   initial begin
      reset = 1;
      req_valid <= 0;
      req_opcode <= OP_VERTEX;
      req_stack_index <= 0;
      req_sector_index <= 0;
      csr_write_enable <= 0;
      csr_index <= CSR_RADIUS;
      csr_data <= 0;
      steady = 0;
      items_sent = 0;
      sectors_now = 36;
      stacks_now = 18;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset defaults.
      directed_items();
      random_items(200);
      settle();

      // Largest radius, fewest divisions, centers at the extremes so positions saturate.
      set_mesh(32'h7FFF_FFFF, 3, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
      directed_items();
      random_items(200);
      settle();

      // Ignored count writes leave the grid as it was; unlisted registers do nothing.
      write_reg(CSR_SECTORS, 2);
      write_reg(CSR_STACKS, 1);
      write_reg(CSR_SECTORS, 257);
      write_reg(CSR_STACKS, 32'hFFFF_FFFF);
      write_reg(3'd6, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'h1234_5678);
      steady = 1;
      random_items(150);
      steady = 0;
      settle();

      // Finest grid, zero radius, negative centers.
      set_mesh(0, 256, 256, 32'h8000_0000, 32'hFFFF_0000, 32'h8000_0000);
      directed_items();
      random_items(150);
      settle();

      // A few random settings, one without any idling.
      for (int p = 0; p < 4; p++) begin
         set_mesh($urandom, $urandom_range(3, 64), $urandom_range(2, 64),
                  $urandom, $urandom, $urandom);
         steady = (p == 2);
         random_items(120);
         steady = 0;
         settle();
      end

      set_mesh(32'h0001_8000, 256, 2, 0, 32'h7FFF_FFFF, 32'hC000_0000);
      random_items(100);
      req_valid <= 0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over eight register settings.", items_sent);
      $display("Checked %0d vertex, %0d triangle and %0d out-of-range beats.",
               vertex_seen, triangle_seen, range_seen);
      if (fail_count == 0 && pending == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
